[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  // Number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS = 16;
  // One divider cell per quotient bit.
  localparam int NCELL = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // Item description travelling alongside the divider lanes.
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        equal;
    status_t     status;
  } tag_t;

  // One quotient lane of the divider.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } lane_t;

  // Saturates a sign-magnitude value to 32 bits; bit 32 flags saturation.
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - mag[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Operand registers, partial products, add/subtract/compare, and divider setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [2:0]          op,
  input  wire logic signed [31:0]  a_re,
  input  wire logic signed [31:0]  a_im,
  input  wire logic signed [31:0]  b_re,
  input  wire logic signed [31:0]  b_im,
  output cau_pkg::tag_t            tag_out,
  output logic [63:0]              den_out,
  output cau_pkg::lane_t           lane_re,
  output cau_pkg::lane_t           lane_im
);

  // Stage A: operand registers.
  logic              va;
  logic [2:0]        opa;
  logic signed [31:0] ar, ai, br, bi;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_valid;
    opa <= op;
    ar  <= a_re;
    ai  <= a_im;
    br  <= b_re;
    bi  <= b_im;
  end

  // Stage B: products, plus the results that need no product.
  cau_pkg::tag_t     tb, tb_next;
  logic [2:0]        opb;
  logic signed [63:0] p_rr, p_ii, p_ri, p_ir, s_rr, s_ii;
  logic signed [32:0] sum_re, sum_im;

  always_comb begin
    tb_next = '0;
    tb_next.valid  = va;
    tb_next.status = cau_pkg::ST_OK;
    if (opa == cau_pkg::OP_SUB) begin
      sum_re = {ar[31], ar} - {br[31], br};
      sum_im = {ai[31], ai} - {bi[31], bi};
    end else begin
      sum_re = {ar[31], ar} + {br[31], br};
      sum_im = {ai[31], ai} + {bi[31], bi};
    end
    case (opa)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        tb_next.res_re = (sum_re[32] != sum_re[31]) ?
                         (sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
        tb_next.res_im = (sum_im[32] != sum_im[31]) ?
                         (sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
        if ((sum_re[32] != sum_re[31]) || (sum_im[32] != sum_im[31]))
          tb_next.status = cau_pkg::ST_SAT;
      end
      cau_pkg::OP_CMP: begin
        tb_next.equal = (ar == br) && (ai == bi);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) tb.valid <= 1'b0;
    else tb.valid <= tb_next.valid;
    tb.is_div <= tb_next.is_div;
    tb.neg_re <= tb_next.neg_re;
    tb.neg_im <= tb_next.neg_im;
    tb.ovf_re <= tb_next.ovf_re;
    tb.ovf_im <= tb_next.ovf_im;
    tb.res_re <= tb_next.res_re;
    tb.res_im <= tb_next.res_im;
    tb.equal  <= tb_next.equal;
    tb.status <= tb_next.status;
    opb  <= opa;
    p_rr <= 64'(ar) * 64'(br);
    p_ii <= 64'(ai) * 64'(bi);
    p_ri <= 64'(ar) * 64'(bi);
    p_ir <= 64'(ai) * 64'(br);
    s_rr <= 64'(br) * 64'(br);
    s_ii <= 64'(bi) * 64'(bi);
  end

  // Stage C: combine products into the two signed parts and |b|^2.
  cau_pkg::tag_t     tc;
  logic [2:0]        opc;
  logic signed [64:0] num_re, num_im;
  logic [63:0]       den_c;

  always_ff @(posedge clk) begin
    if (rst) tc.valid <= 1'b0;
    else tc.valid <= tb.valid;
    tc.is_div <= tb.is_div;
    tc.neg_re <= tb.neg_re;
    tc.neg_im <= tb.neg_im;
    tc.ovf_re <= tb.ovf_re;
    tc.ovf_im <= tb.ovf_im;
    tc.res_re <= tb.res_re;
    tc.res_im <= tb.res_im;
    tc.equal  <= tb.equal;
    tc.status <= tb.status;
    opc <= opb;
    if (opb == cau_pkg::OP_MUL) begin
      num_re <= {p_rr[63], p_rr} - {p_ii[63], p_ii};
      num_im <= {p_ri[63], p_ri} + {p_ir[63], p_ir};
    end else begin
      num_re <= {p_rr[63], p_rr} + {p_ii[63], p_ii};
      num_im <= {p_ir[63], p_ir} - {p_ri[63], p_ri};
    end
    den_c <= s_rr + s_ii;
  end

  // Stage D: sign and magnitude.
  cau_pkg::tag_t tdd;
  logic [2:0]    opd;
  logic [63:0]   mag_re, mag_im, den_d;
  logic [64:0]   neg_num_re, neg_num_im;

  assign neg_num_re = 65'd0 - num_re;
  assign neg_num_im = 65'd0 - num_im;

  always_ff @(posedge clk) begin
    if (rst) tdd.valid <= 1'b0;
    else tdd.valid <= tc.valid;
    tdd.is_div <= tc.is_div;
    tdd.neg_re <= num_re[64];
    tdd.neg_im <= num_im[64];
    tdd.ovf_re <= tc.ovf_re;
    tdd.ovf_im <= tc.ovf_im;
    tdd.res_re <= tc.res_re;
    tdd.res_im <= tc.res_im;
    tdd.equal  <= tc.equal;
    tdd.status <= tc.status;
    opd    <= opc;
    mag_re <= num_re[64] ? neg_num_re[63:0] : num_re[63:0];
    mag_im <= num_im[64] ? neg_num_im[63:0] : num_im[63:0];
    den_d  <= den_c;
  end

  // Stage E: product saturation, divider overflow test and first remainder.
  cau_pkg::tag_t te;
  logic [63:0]   shr_re, shr_im;
  logic [32:0]   sat_re, sat_im;
  logic [96:0]   den_w, lim;
  logic [63:0]   mre_sh, mim_sh;

  always_comb begin
    shr_re = mag_re >> cau_pkg::FRAC_BITS;
    shr_im = mag_im >> cau_pkg::FRAC_BITS;
    sat_re = cau_pkg::sat_mag(tdd.neg_re, shr_re);
    sat_im = cau_pkg::sat_mag(tdd.neg_im, shr_im);
    den_w  = {33'd0, den_d};
    lim    = den_w << (32 - cau_pkg::FRAC_BITS);
    mre_sh = mag_re << cau_pkg::FRAC_BITS;
    mim_sh = mag_im << cau_pkg::FRAC_BITS;
    te = tdd;
    case (opd)
      cau_pkg::OP_MUL: begin
        te.res_re = sat_re[31:0];
        te.res_im = sat_im[31:0];
        te.status = (sat_re[32] || sat_im[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      cau_pkg::OP_DIV: begin
        if (den_d == 64'd0) begin
          te.status = cau_pkg::ST_DIVZ;
        end else begin
          te.is_div = 1'b1;
          te.ovf_re = {33'd0, mag_re} >= lim;
          te.ovf_im = {33'd0, mag_im} >= lim;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) tag_out.valid <= 1'b0;
    else tag_out.valid <= te.valid;
    tag_out.is_div <= te.is_div;
    tag_out.neg_re <= te.neg_re;
    tag_out.neg_im <= te.neg_im;
    tag_out.ovf_re <= te.ovf_re;
    tag_out.ovf_im <= te.ovf_im;
    tag_out.res_re <= te.res_re;
    tag_out.res_im <= te.res_im;
    tag_out.equal  <= te.equal;
    tag_out.status <= te.status;
    den_out     <= den_d;
    lane_re.rem <= mag_re >> (32 - cau_pkg::FRAC_BITS);
    lane_re.low <= mre_sh[31:0];
    lane_re.q   <= 32'd0;
    lane_im.rem <= mag_im >> (32 - cau_pkg::FRAC_BITS);
    lane_im.low <= mim_sh[31:0];
    lane_im.q   <= 32'd0;
  end

endmodule

`default_nettype wire

[rtl/cau_div_cell.sv]
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both quotient lanes, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cau_div_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  cau_pkg::tag_t     tag_in,
  input  wire logic [63:0]  den_in,
  input  cau_pkg::lane_t    re_in,
  input  cau_pkg::lane_t    im_in,
  output cau_pkg::tag_t     tag_out,
  output logic [63:0]       den_out,
  output cau_pkg::lane_t    re_out,
  output cau_pkg::lane_t    im_out
);

  // Shift in the next dividend bit and subtract the divisor when it fits.
  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [63:0] d);
    cau_pkg::lane_t r;
    logic [64:0]    t;
    logic [64:0]    diff;
    logic           ge;
    t    = {l.rem, l.low[31]};
    diff = t - {1'b0, d};
    ge   = t >= {1'b0, d};
    r.rem = ge ? diff[63:0] : t[63:0];
    r.low = {l.low[30:0], 1'b0};
    r.q   = {l.q[30:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) tag_out.valid <= 1'b0;
    else tag_out.valid <= tag_in.valid;
    tag_out.is_div <= tag_in.is_div;
    tag_out.neg_re <= tag_in.neg_re;
    tag_out.neg_im <= tag_in.neg_im;
    tag_out.ovf_re <= tag_in.ovf_re;
    tag_out.ovf_im <= tag_in.ovf_im;
    tag_out.res_re <= tag_in.res_re;
    tag_out.res_im <= tag_in.res_im;
    tag_out.equal  <= tag_in.equal;
    tag_out.status <= tag_in.status;
    den_out <= den_in;
    re_out  <= step(re_in, den_in);
    im_out  <= step(im_in, den_in);
  end

endmodule

`default_nettype wire

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and compare in signed Q16.16.
// ----------------------------------------------------------------------------
// The unit takes one transfer in every clock cycle: busy is always low, so
// start alone commits an item. Every item, whatever its operation, passes
// through the same path of five front stages, one divider cell per quotient
// bit and the output register, and results come out in the order the items
// went in. Each result stands on the result ports for exactly one cycle with
// done high; the receiver cannot stall the unit and must take it then. The
// latency is set by the chain of 32 divider cells, each of which retires one
// quotient bit of both parts per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         op,
  input  wire logic signed [31:0] a_re,
  input  wire logic signed [31:0] a_im,
  input  wire logic signed [31:0] b_re,
  input  wire logic signed [31:0] b_im,
  output logic                    done,
  output logic signed [31:0]      res_re,
  output logic signed [31:0]      res_im,
  output logic                    equal,
  output logic [1:0]              status
);

  // The pipeline never holds off a transfer.
  assign busy = 1'b0;

  // Chain links: index 0 is the front end output, index NCELL the last cell.
  cau_pkg::tag_t  tag  [cau_pkg::NCELL+1];
  logic [63:0]    den  [cau_pkg::NCELL+1];
  cau_pkg::lane_t lre  [cau_pkg::NCELL+1];
  cau_pkg::lane_t lim  [cau_pkg::NCELL+1];

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .op       (op),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .tag_out  (tag[0]),
    .den_out  (den[0]),
    .lane_re  (lre[0]),
    .lane_im  (lim[0])
  );

  // Each cell produces one quotient bit, most significant first.
  for (genvar g = 0; g < cau_pkg::NCELL; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tag_in  (tag[g]),
      .den_in  (den[g]),
      .re_in   (lre[g]),
      .im_in   (lim[g]),
      .tag_out (tag[g+1]),
      .den_out (den[g+1]),
      .re_out  (lre[g+1]),
      .im_out  (lim[g+1])
    );
  end

  // Quotients flagged as too large stand in as 2^32, which always saturates.
  cau_pkg::tag_t last;
  logic [63:0]   qre, qim;
  logic [32:0]   sre, sim;

  assign last = tag[cau_pkg::NCELL];

  always_comb begin
    qre = last.ovf_re ? 64'h0000_0001_0000_0000 : {32'd0, lre[cau_pkg::NCELL].q};
    qim = last.ovf_im ? 64'h0000_0001_0000_0000 : {32'd0, lim[cau_pkg::NCELL].q};
    sre = cau_pkg::sat_mag(last.neg_re, qre);
    sim = cau_pkg::sat_mag(last.neg_im, qim);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= last.valid;
    equal <= last.equal;
    if (last.is_div) begin
      res_re <= sre[31:0];
      res_im <= sim[31:0];
      status <= (sre[32] || sim[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      res_re <= last.res_re;
      res_im <= last.res_im;
      status <= last.status;
    end
  end

endmodule

`default_nettype wire
